@@ rtl/core/graph_bfs_dfs_traversal_core_macros.svh @@
// ----------------------------------------------------------------------------
// graph traversal core assertion macros
// shared property wrappers for the traversal core
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_CORE_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_CORE_MACROS_SVH

// checked only while out of reset
`define GTRAV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define GTRAV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/gtrav_pkg.sv @@
// ----------------------------------------------------------------------------
// gtrav_pkg
// types and codes shared by the graph traversal core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gtrav_pkg;

  localparam int NODE_W = 5;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  localparam logic [ST_W-1:0] ST_VISIT   = 2'd0;
  localparam logic [ST_W-1:0] ST_STORED  = 2'd1;
  localparam logic [ST_W-1:0] ST_DROPPED = 2'd2;
  localparam logic [ST_W-1:0] ST_CLEARED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              one_way;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] visited_node;
    logic [ST_W-1:0]   status;
    logic              last;
  } out_item_t;

endpackage

@@ rtl/core/gtrav_in_if.sv @@
// ----------------------------------------------------------------------------
// gtrav_in_if
// command channel of the traversal core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface gtrav_in_if;
  logic                valid;
  logic                ready;
  gtrav_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/gtrav_out_if.sv @@
// ----------------------------------------------------------------------------
// gtrav_out_if
// result channel of the traversal core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface gtrav_out_if;
  logic                 valid;
  logic                 ready;
  gtrav_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/gtrav_ram.sv @@
// ----------------------------------------------------------------------------
// gtrav_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gtrav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/graph_bfs_dfs_traversal_core.sv @@
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_core
// adjacency list store with breadth-first and depth-first walk
// ----------------------------------------------------------------------------
// One command is worked at a time; the command channel is ready whenever the
// sequencer is idle, even while a result sits in the output register. An add
// edge reads both list lengths, writes the first entry, writes the second entry
// for an undirected edge and then sends its result; a clear resets the list
// lengths and sends its result. A breadth-first walk pops a node, reads its length
// and scans each stored neighbour; a depth-first walk reads each node's length,
// scans its neighbours and pops the stack when it returns to a node. The list length,
// neighbour, queue and stack memories all have a registered read port. Results
// stall the walk only while the output register is full and out_o is not ready.
`timescale 1ns / 1ps
`include "graph_bfs_dfs_traversal_core_macros.svh"
module graph_bfs_dfs_traversal_core #(
  parameter int NODE_COUNT = 32,
  parameter int MAX_DEGREE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  gtrav_in_if.sink    in_i,
  gtrav_out_if.source out_o
);
  import gtrav_pkg::*;

  localparam int NIW = $clog2(NODE_COUNT);
  localparam int CW  = $clog2(NODE_COUNT + 1);
  localparam int LW  = $clog2(MAX_DEGREE + 1);
  localparam int NBD = NODE_COUNT * MAX_DEGREE;
  localparam int NAW = $clog2(NBD);
  localparam int SW  = NIW + LW;
  localparam logic [LW:0] MaxDeg = (LW + 1)'(MAX_DEGREE);
  localparam logic [6:0]  NodeLim = 7'(NODE_COUNT);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_LA   = 4'd1;
  localparam logic [3:0] S_ADD_LB   = 4'd2;
  localparam logic [3:0] S_ADD_B    = 4'd3;
  localparam logic [3:0] S_RESP     = 4'd4;
  localparam logic [3:0] S_BFS_POP  = 4'd5;
  localparam logic [3:0] S_BFS_NODE = 4'd6;
  localparam logic [3:0] S_BFS_LEN  = 4'd7;
  localparam logic [3:0] S_BFS_SCAN = 4'd8;
  localparam logic [3:0] S_BFS_CHK  = 4'd9;
  localparam logic [3:0] S_DFS_LREQ = 4'd10;
  localparam logic [3:0] S_DFS_LEN  = 4'd11;
  localparam logic [3:0] S_DFS_SCAN = 4'd12;
  localparam logic [3:0] S_DFS_CHK  = 4'd13;
  localparam logic [3:0] S_DFS_POP  = 4'd14;
  localparam logic [3:0] S_FIN      = 4'd15;

  logic [3:0]            state_q, state_d;
  logic                  order_q;
  logic [NODE_W-1:0]     a_q, a_d, b_q, b_d;
  logic                  ow_q, ow_d;
  logic [LW-1:0]         la_q, la_d, lb_q, lb_d;
  logic [ST_W-1:0]       resp_q, resp_d;
  logic [LW-1:0]         len_q, len_d, pos_q, pos_d;
  logic [NIW-1:0]        cur_q, cur_d;
  logic [CW-1:0]         head_q, head_d, tail_q, tail_d, depth_q, depth_d;
  logic                  hold_vld_q, hold_vld_d;
  logic [NIW-1:0]        hold_node_q, hold_node_d;
  logic [NODE_COUNT-1:0] visited_q, visited_d;
  logic [NODE_COUNT-1:0] len_vld_q, len_vld_d;
  logic                  len_rvld_q;
  logic                  out_vld_q;
  out_item_t             out_q;

  logic                  emit, can_emit;
  out_item_t             emit_item;

  logic                  len_we;
  logic [NIW-1:0]        len_waddr, len_raddr;
  logic [LW-1:0]         len_wdata, len_rdata, len_rd;
  logic                  nbr_we;
  logic [NAW-1:0]        nbr_waddr, nbr_raddr;
  logic [NODE_W-1:0]     nbr_wdata, nbr_rdata;
  logic                  pq_we;
  logic [NIW-1:0]        pq_waddr, pq_wdata, pq_raddr, pq_rdata;
  logic                  stk_we;
  logic [NIW-1:0]        stk_waddr, stk_raddr;
  logic [SW-1:0]         stk_wdata, stk_rdata;

  logic [6:0]            in_a7, a7, b7, nb7;
  logic [NIW-1:0]        in_a_idx, a_idx, b_idx, nb_idx;
  logic                  in_a_ok, ab_ok, nb_ok;
  logic [LW:0]           la_x, lb_x;
  logic                  add_ok;
  logic [CW-1:0]         depth_m1, depth_m2;
  logic                  in_fire;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign can_emit = !out_vld_q || out_o.ready;

  assign in_a7    = 7'(in_i.payload.node_a);
  assign in_a_idx = in_a7[NIW-1:0];
  assign in_a_ok  = in_a7 < NodeLim;
  assign a7       = 7'(a_q);
  assign b7       = 7'(b_q);
  assign a_idx    = a7[NIW-1:0];
  assign b_idx    = b7[NIW-1:0];
  assign ab_ok    = (a7 < NodeLim) && (b7 < NodeLim);
  assign nb7      = 7'(nbr_rdata);
  assign nb_idx   = nb7[NIW-1:0];
  assign nb_ok    = nb7 < NodeLim;
  assign len_rd   = len_rvld_q ? len_rdata : '0;
  assign la_x     = (LW + 1)'(la_q);
  assign lb_x     = (LW + 1)'(len_rd);
  assign depth_m1 = depth_q - CW'(1);
  assign depth_m2 = depth_q - CW'(2);

  always_comb begin
    if (ow_q) begin
      add_ok = la_x < MaxDeg;
    end else if (a_q == b_q) begin
      add_ok = (la_x + (LW + 1)'(2)) <= MaxDeg;
    end else begin
      add_ok = (la_x < MaxDeg) && (lb_x < MaxDeg);
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:              len_raddr = in_a_idx;
      S_ADD_LA, S_ADD_LB:  len_raddr = b_idx;
      S_BFS_NODE:          len_raddr = pq_rdata;
      default:             len_raddr = cur_q;
    endcase
  end

  assign nbr_raddr = NAW'(int'(cur_q) * MAX_DEGREE + int'(pos_q));
  assign pq_raddr  = head_q[NIW-1:0];
  assign stk_raddr = depth_m2[NIW-1:0];
  assign stk_waddr = depth_m1[NIW-1:0];
  assign stk_wdata = {cur_q, pos_q + LW'(1)};

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    ow_d        = ow_q;
    la_d        = la_q;
    lb_d        = lb_q;
    resp_d      = resp_q;
    len_d       = len_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    head_d      = head_q;
    tail_d      = tail_q;
    depth_d     = depth_q;
    hold_vld_d  = hold_vld_q;
    hold_node_d = hold_node_q;
    visited_d   = visited_q;
    len_vld_d   = len_vld_q;
    emit        = 1'b0;
    emit_item   = '{visited_node: '0, status: ST_VISIT, last: 1'b0};
    len_we      = 1'b0;
    len_waddr   = a_idx;
    len_wdata   = la_q + LW'(1);
    nbr_we      = 1'b0;
    nbr_waddr   = NAW'(int'(a_idx) * MAX_DEGREE + int'(la_q));
    nbr_wdata   = b_q;
    pq_we       = 1'b0;
    pq_waddr    = tail_q[NIW-1:0];
    pq_wdata    = nb_idx;
    stk_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          a_d  = in_i.payload.node_a;
          b_d  = in_i.payload.node_b;
          ow_d = in_i.payload.one_way;
          priority case (in_i.payload.cmd)
            CMD_ADD_EDGE: begin
              state_d = S_ADD_LA;
            end
            CMD_TRAVERSE: begin
              if (in_a_ok) begin
                visited_d           = '0;
                visited_d[in_a_idx] = 1'b1;
                if (order_q) begin
                  hold_vld_d  = 1'b1;
                  hold_node_d = in_a_idx;
                  cur_d       = in_a_idx;
                  pos_d       = '0;
                  depth_d     = CW'(1);
                  state_d     = S_DFS_LREQ;
                end else begin
                  pq_we    = 1'b1;
                  pq_waddr = '0;
                  pq_wdata = in_a_idx;
                  head_d   = '0;
                  tail_d   = CW'(1);
                  state_d  = S_BFS_POP;
                end
              end
            end
            CMD_CLEAR: begin
              len_vld_d = '0;
              resp_d    = ST_CLEARED;
              state_d   = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_ADD_LA: begin
        la_d = len_rd;
        if (ab_ok) begin
          state_d = S_ADD_LB;
        end else begin
          resp_d  = ST_DROPPED;
          state_d = S_RESP;
        end
      end
      S_ADD_LB: begin
        if (add_ok) begin
          nbr_we           = 1'b1;
          len_we           = 1'b1;
          len_vld_d[a_idx] = 1'b1;
          lb_d             = (a_q == b_q) ? (la_q + LW'(1)) : len_rd;
          if (ow_q) begin
            resp_d  = ST_STORED;
            state_d = S_RESP;
          end else begin
            state_d = S_ADD_B;
          end
        end else begin
          resp_d  = ST_DROPPED;
          state_d = S_RESP;
        end
      end
      S_ADD_B: begin
        nbr_we           = 1'b1;
        nbr_waddr        = NAW'(int'(b_idx) * MAX_DEGREE + int'(lb_q));
        nbr_wdata        = a_q;
        len_we           = 1'b1;
        len_waddr        = b_idx;
        len_wdata        = lb_q + LW'(1);
        len_vld_d[b_idx] = 1'b1;
        resp_d           = ST_STORED;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_item = '{visited_node: '0, status: resp_q, last: 1'b1};
          state_d   = S_IDLE;
        end
      end
      S_BFS_POP: begin
        state_d = (head_q == tail_q) ? S_FIN : S_BFS_NODE;
      end
      S_BFS_NODE: begin
        if (!hold_vld_q || can_emit) begin
          emit        = hold_vld_q;
          emit_item   = '{visited_node: NODE_W'(hold_node_q), status: ST_VISIT, last: 1'b0};
          hold_vld_d  = 1'b1;
          hold_node_d = pq_rdata;
          cur_d       = pq_rdata;
          head_d      = head_q + CW'(1);
          state_d     = S_BFS_LEN;
        end
      end
      S_BFS_LEN: begin
        len_d   = len_rd;
        pos_d   = '0;
        state_d = S_BFS_SCAN;
      end
      S_BFS_SCAN: begin
        state_d = (pos_q < len_q) ? S_BFS_CHK : S_BFS_POP;
      end
      S_BFS_CHK: begin
        if (nb_ok && !visited_q[nb_idx] && (tail_q < CW'(NODE_COUNT))) begin
          visited_d[nb_idx] = 1'b1;
          pq_we             = 1'b1;
          tail_d            = tail_q + CW'(1);
        end
        pos_d   = pos_q + LW'(1);
        state_d = S_BFS_SCAN;
      end
      S_DFS_LREQ: begin
        state_d = S_DFS_LEN;
      end
      S_DFS_LEN: begin
        len_d   = len_rd;
        state_d = S_DFS_SCAN;
      end
      S_DFS_SCAN: begin
        if (pos_q < len_q) begin
          state_d = S_DFS_CHK;
        end else if (depth_q == CW'(1)) begin
          state_d = S_FIN;
        end else begin
          depth_d = depth_m1;
          state_d = S_DFS_POP;
        end
      end
      S_DFS_CHK: begin
        if (nb_ok && !visited_q[nb_idx] && (depth_q < CW'(NODE_COUNT))) begin
          if (can_emit) begin
            emit              = 1'b1;
            emit_item         = '{visited_node: NODE_W'(hold_node_q), status: ST_VISIT,
                                  last: 1'b0};
            hold_node_d       = nb_idx;
            visited_d[nb_idx] = 1'b1;
            stk_we            = 1'b1;
            cur_d             = nb_idx;
            pos_d             = '0;
            depth_d           = depth_q + CW'(1);
            state_d           = S_DFS_LREQ;
          end
        end else begin
          pos_d   = pos_q + LW'(1);
          state_d = S_DFS_SCAN;
        end
      end
      S_DFS_POP: begin
        cur_d   = stk_rdata[SW-1:LW];
        pos_d   = stk_rdata[LW-1:0];
        state_d = S_DFS_LREQ;
      end
      S_FIN: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_item  = '{visited_node: NODE_W'(hold_node_q), status: ST_VISIT, last: 1'b1};
          hold_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      order_q    <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      depth_q    <= '0;
      hold_vld_q <= 1'b0;
      visited_q  <= '0;
      len_vld_q  <= '0;
      len_rvld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      depth_q    <= depth_d;
      hold_vld_q <= hold_vld_d;
      visited_q  <= visited_d;
      len_vld_q  <= len_vld_d;
      len_rvld_q <= len_vld_q[len_raddr];
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    ow_q        <= ow_d;
    la_q        <= la_d;
    lb_q        <= lb_d;
    resp_q      <= resp_d;
    len_q       <= len_d;
    pos_q       <= pos_d;
    cur_q       <= cur_d;
    hold_node_q <= hold_node_d;
    if (emit) begin
      out_q <= emit_item;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  gtrav_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  gtrav_ram #(.WIDTH(NODE_W), .DEPTH(NBD)) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nbr_we),
    .waddr_i (nbr_waddr),
    .wdata_i (nbr_wdata),
    .raddr_i (nbr_raddr),
    .rdata_o (nbr_rdata)
  );

  gtrav_ram #(.WIDTH(NIW), .DEPTH(NODE_COUNT)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (pq_we),
    .waddr_i (pq_waddr),
    .wdata_i (pq_wdata),
    .raddr_i (pq_raddr),
    .rdata_o (pq_rdata)
  );

  gtrav_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  `GTRAV_ASSERT_ALWAYS(a_idle_no_hold, (state_q == S_IDLE) |-> !hold_vld_q, "held visit left at idle")
  `GTRAV_ASSERT(a_queue_order, head_q <= tail_q, "queue head passed tail")
  `GTRAV_ASSERT(a_depth_bound, depth_q <= CW'(NODE_COUNT), "stack depth overflow")
  `GTRAV_ASSERT(a_walk_start, (in_fire && (in_i.payload.cmd == CMD_TRAVERSE) && in_a_ok) |=> ($countones(visited_q) == 1), "visited marks not reset at walk start")
  `GTRAV_ASSERT(a_emit_room, emit |-> can_emit, "result written over pending output")

endmodule

@@ tb/gtrav_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// gtrav_tb_pkg
// shared testbench settings for the traversal core bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gtrav_tb_pkg;

  localparam int NODES  = 32;
  localparam int DEGREE = 16;

  localparam logic ORDER_BREADTH = 1'b0;
  localparam logic ORDER_DEPTH   = 1'b1;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

endpackage

@@ tb/gtrav_tb_if.sv @@
// ----------------------------------------------------------------------------
// gtrav_tb_if
// configuration write port bundle used by the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface gtrav_cfg_if;
  logic we;
  logic wdata;

  modport source (output we, output wdata);
  modport sink (input we, input wdata);
endinterface

@@ tb/gtrav_walk_checker.sv @@
// ----------------------------------------------------------------------------
// gtrav_walk_checker
// tracks the graph and predicts the result stream of each command transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gtrav_walk_checker
  import gtrav_pkg::*;
  import gtrav_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 cmd_valid_i,
  input  logic                 cmd_ready_i,
  input  in_item_t             cmd_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  out_item_t            res_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int EXP_DEPTH = 64;

  logic [NODE_W-1:0] adj_q [NODES][DEGREE];
  int                adj_len [NODES];
  logic              seen [NODES];
  logic              order_q;
  out_item_t         exp_q [EXP_DEPTH];
  int                exp_wr;
  int                exp_rd;

  function automatic logic [1:0] link_nodes(logic [4:0] a, logic [4:0] b, logic one_way);
    if (one_way) begin
      if (adj_len[a] >= DEGREE) return ST_DROPPED;
      adj_q[a][adj_len[a]] = b;
      adj_len[a]++;
      return ST_STORED;
    end
    if (a == b) begin
      if (adj_len[a] + 2 > DEGREE) return ST_DROPPED;
    end else if (adj_len[a] >= DEGREE || adj_len[b] >= DEGREE) begin
      return ST_DROPPED;
    end
    adj_q[a][adj_len[a]] = b;
    adj_len[a]++;
    adj_q[b][adj_len[b]] = a;
    adj_len[b]++;
    return ST_STORED;
  endfunction

  function automatic void add_expected(out_item_t r);
    exp_q[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic void push_visit(logic [4:0] n);
    out_item_t r;
    r.visited_node = n;
    r.status       = ST_VISIT;
    r.last         = 1'b0;
    add_expected(r);
  endfunction

  function automatic void walk_graph(logic [4:0] start);
    logic [4:0] fifo [NODES];
    logic [4:0] stk_node [NODES];
    int         stk_pos [NODES];
    int         fhead;
    int         ftail;
    int         sd;
    logic [4:0] n;
    logic [4:0] nb;
    int         first;
    first = exp_wr;
    for (int i = 0; i < NODES; i++) seen[i] = 1'b0;
    seen[start] = 1'b1;
    if (order_q == ORDER_BREADTH) begin
      fifo[0] = start;
      fhead = 0;
      ftail = 1;
      while (fhead < ftail) begin
        n = fifo[fhead];
        fhead++;
        push_visit(n);
        for (int i = 0; i < adj_len[n]; i++) begin
          nb = adj_q[n][i];
          if (!seen[nb] && ftail < NODES) begin
            seen[nb] = 1'b1;
            fifo[ftail] = nb;
            ftail++;
          end
        end
      end
    end else begin
      push_visit(start);
      stk_node[0] = start;
      stk_pos[0] = 0;
      sd = 1;
      while (sd > 0) begin
        n = stk_node[sd - 1];
        if (stk_pos[sd - 1] < adj_len[n]) begin
          nb = adj_q[n][stk_pos[sd - 1]];
          stk_pos[sd - 1] = stk_pos[sd - 1] + 1;
          if (!seen[nb] && sd < NODES) begin
            seen[nb] = 1'b1;
            push_visit(nb);
            stk_node[sd] = nb;
            stk_pos[sd] = 0;
            sd++;
          end
        end else begin
          sd--;
        end
      end
    end
    if (exp_wr > first) begin
      exp_q[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
    end
  endfunction

  assign pending_o = exp_wr - exp_rd;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t r;
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) adj_len[i] = 0;
      order_q = ORDER_BREADTH;
      exp_wr = 0;
      exp_rd = 0;
      errors_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result exp none act %p", $time, res_i);
          errors_o <= errors_o + 1;
        end else begin
          want = exp_q[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (res_i !== want) begin
            $display("%0t: result mismatch exp node %0d st %0d last %0d act node %0d st %0d last %0d",
                     $time, want.visited_node, want.status, want.last,
                     res_i.visited_node, res_i.status, res_i.last);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_we_i) order_q = cfg_wdata_i;
      if (cmd_valid_i && cmd_ready_i) begin
        r = '0;
        r.last = 1'b1;
        case (cmd_i.cmd)
          CMD_ADD_EDGE: begin
            r.status = link_nodes(cmd_i.node_a, cmd_i.node_b, cmd_i.one_way);
            add_expected(r);
          end
          CMD_TRAVERSE: walk_graph(cmd_i.node_a);
          CMD_CLEAR: begin
            for (int i = 0; i < NODES; i++) adj_len[i] = 0;
            r.status = ST_CLEARED;
            add_expected(r);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/tb_graph_bfs_dfs_traversal_core.sv @@
// ----------------------------------------------------------------------------
// tb_graph_bfs_dfs_traversal_core
// drives edge, walk and clear commands in both walk orders under random
// source gaps and sink stalls; the checker compares every result transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_graph_bfs_dfs_traversal_core;
  import gtrav_pkg::*;
  import gtrav_tb_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  bit   timed_out;

  gtrav_in_if  cmd_if ();
  gtrav_out_if res_if ();
  gtrav_cfg_if cfg_if ();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  graph_bfs_dfs_traversal_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_if.we),
    .cfg_wdata_i (cfg_if.wdata),
    .in_i        (cmd_if),
    .out_o       (res_if)
  );

  gtrav_walk_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_if.we),
    .cfg_wdata_i (cfg_if.wdata),
    .cmd_valid_i (cmd_if.valid),
    .cmd_ready_i (cmd_if.ready),
    .cmd_i       (cmd_if.payload),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_i       (res_if.payload),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    res_if.ready   = 1'b0;
    cfg_if.we      = 1'b0;
    cfg_if.wdata   = 1'b0;
  end

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG);
    timed_out = 1'b1;
  end

  task automatic send_cmd(logic [1:0] cmd, logic [4:0] a, logic [4:0] b, logic one_way);
    in_item_t it;
    int       gap;
    it.cmd = cmd;
    it.node_a = a;
    it.node_b = b;
    it.one_way = one_way;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= it;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic set_order(logic order);
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_if.we    <= 1'b1;
    cfg_if.wdata <= order;
    @(posedge clk_i);
    cfg_if.we <= 1'b0;
  endtask

  task automatic random_cmd(int span);
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      send_cmd(CMD_ADD_EDGE, 5'($urandom_range(span - 1)), 5'($urandom_range(span - 1)),
               1'($urandom_range(1)));
    else if (pick < 92)
      send_cmd(CMD_TRAVERSE, 5'($urandom_range(31)), 5'($urandom), 1'($urandom));
    else if (pick < 97) send_cmd(CMD_CLEAR, 5'($urandom), 5'($urandom), 1'($urandom));
    else send_cmd(CMD_UNKNOWN, 5'($urandom), 5'($urandom), 1'($urandom));
  endtask

  initial begin
    quiet_cycles = 0;
    timed_out = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, self loops, full lists, both orders
    send_cmd(CMD_ADD_EDGE, 5'd0, 5'd31, 1'b0);
    send_cmd(CMD_ADD_EDGE, 5'd31, 5'd31, 1'b0);
    send_cmd(CMD_ADD_EDGE, 5'd0, 5'd0, 1'b1);
    send_cmd(CMD_ADD_EDGE, 5'd0, 5'd10, 1'b1);
    send_cmd(CMD_ADD_EDGE, 5'd10, 5'd21, 1'b0);
    send_cmd(CMD_TRAVERSE, 5'd0, 5'd31, 1'b1);
    send_cmd(CMD_TRAVERSE, 5'd7, 5'd0, 1'b0);
    send_cmd(CMD_UNKNOWN, 5'd31, 5'd31, 1'b1);
    for (int i = 0; i < 17; i++) send_cmd(CMD_ADD_EDGE, 5'd3, 5'(i + 4), i[0]);
    send_cmd(CMD_ADD_EDGE, 5'd4, 5'd4, 1'b0);
    send_cmd(CMD_TRAVERSE, 5'd3, 5'd0, 1'b0);
    set_order(ORDER_DEPTH);
    send_cmd(CMD_TRAVERSE, 5'd3, 5'd0, 1'b0);
    send_cmd(CMD_TRAVERSE, 5'd0, 5'd0, 1'b0);
    send_cmd(CMD_CLEAR, 5'd31, 5'd31, 1'b1);
    send_cmd(CMD_TRAVERSE, 5'd3, 5'd0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      set_order(ph[0] ? ORDER_BREADTH : ORDER_DEPTH);
      for (int k = 0; k < 37; k++) random_cmd((ph < 4) ? 8 : 32);
      send_cmd(CMD_TRAVERSE, 5'($urandom_range(7)), 5'd0, 1'b0);
    end

    cmd_if.valid <= 1'b0;
    stall_pct = 0;
    @(posedge clk_i);
    while (pending != 0 && !timed_out) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (timed_out) begin
      $display("[graph_bfs_dfs_traversal_core] ERROR");
    end else if (errors == 0) begin
      $display("[graph_bfs_dfs_traversal_core] OK");
    end else begin
      $display("[graph_bfs_dfs_traversal_core] ERROR");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("[graph_bfs_dfs_traversal_core] ERROR");
    $finish;
  end

endmodule
